>>> sv/assert_macros.svh
// Assertion helpers for the RTL of the ARP cache resolver.
// Every macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge while reset is released.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Overlapping implication: cons must hold in the cycle of ante.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/arpc_pkg.sv
// Types and constants for the ARP cache resolver.
// No dependencies; imported by arp_cache_resolver.
`default_nettype none

package arpc_pkg;

    localparam logic [1:0] OP_RESOLVE = 2'd0;
    localparam logic [1:0] OP_FRAME   = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [3:0] K_RESOLVED = 4'd0;
    localparam logic [3:0] K_HELD     = 4'd1;
    localparam logic [3:0] K_REQUEST  = 4'd2;
    localparam logic [3:0] K_REPLY    = 4'd3;
    localparam logic [3:0] K_RELEASE  = 4'd4;
    localparam logic [3:0] K_LEARNED  = 4'd5;
    localparam logic [3:0] K_AGED     = 4'd6;
    localparam logic [3:0] K_DROPPED  = 4'd7;
    localparam logic [3:0] K_FULL     = 4'd8;
    localparam logic [3:0] K_NONE     = 4'd9;

    localparam logic [1:0] DR_LENGTH = 2'd0;
    localparam logic [1:0] DR_FIELDS = 2'd1;
    localparam logic [1:0] DR_NOTME  = 2'd2;
    localparam logic [1:0] DR_OPER   = 2'd3;

    localparam logic [2:0] CFG_MY_IP     = 3'd0;
    localparam logic [2:0] CFG_MY_MAC    = 3'd1;
    localparam logic [2:0] CFG_SWEEP     = 3'd2;
    localparam logic [2:0] CFG_IDLE      = 3'd3;
    localparam logic [2:0] CFG_RETRY_GAP = 3'd4;
    localparam logic [2:0] CFG_BURST     = 3'd5;
    localparam logic [2:0] CFG_BACKOFF   = 3'd6;

    localparam logic [31:0] LOOPBACK_IP = 32'h7F00_0001;
    localparam logic [15:0] FRAME_LEN   = 16'd46;
    localparam logic [15:0] HW_ETHER    = 16'd1;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN      = 8'd6;
    localparam logic [7:0]  PROTO_LEN   = 8'd4;
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_REPLY   = 16'd2;

    localparam int          MAX_RESULTS = 16;
    localparam logic [4:0]  MAX_RES_CNT = 5'd16;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic        known;
        logic [31:0] last_used;
        logic [31:0] last_sent;
        logic [3:0]  tries;
    } entry_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [1:0]  reason;
    } result_t;

endpackage

`default_nettype wire

>>> sv/arp_cache_resolver.sv
// ARP cache resolver: a resolve request, a parsed ARP frame or a one-second tick per
// transaction. A resolve or reply frame scans the slots in order until it finds a match, and
// its result passes through the pending and output registers; a sweep scans every slot unless
// the result limit ends it early, and can wait on output stalls. One transaction at a time; the
// scan presents each slot to the entry memory and evaluates only occupied rows in a second state.
// Reset (synchronous, active low) clears all valid bits, time, control state and configuration
// registers to defaults; the entry memory itself is not cleared and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module arp_cache_resolver #(
    parameter int ENTRIES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration writes.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    // Input transactions.
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [31:0] s_ip_address,
    input  wire logic [31:0] s_target_ip,
    input  wire logic [47:0] s_sender_mac,
    input  wire logic [15:0] s_hardware_type,
    input  wire logic [15:0] s_protocol_type,
    input  wire logic [7:0]  s_hw_addr_len,
    input  wire logic [7:0]  s_proto_addr_len,
    input  wire logic [15:0] s_arp_operation,
    input  wire logic [15:0] s_frame_length,
    // Result transactions.
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_result_kind,
    output logic [31:0]      m_peer_ip,
    output logic [47:0]      m_peer_mac,
    output logic [1:0]       m_drop_reason,
    output logic             m_last
);
    import arpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Controller states. Lookup and sweep each take two states per occupied slot: one to
    // present the address to the memory, one to evaluate the registered row. Empty slots skip the second.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LK_RD = 3'd1;
    localparam logic [2:0] S_LK_EV = 3'd2;
    localparam logic [2:0] S_MISS  = 3'd3;
    localparam logic [2:0] S_SW_RD = 3'd4;
    localparam logic [2:0] S_SW_EV = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    // Configuration registers.
    logic [31:0] my_ip_reg;
    logic [47:0] my_mac_reg;
    logic [7:0]  sweep_reg;
    logic [15:0] idle_reg;
    logic [7:0]  rgap_reg;
    logic [3:0]  burst_reg;
    logic [15:0] bgap_reg;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               free_ok_reg, free_ok_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]        now_reg, now_next;
    logic [7:0]         cd_reg, cd_next;

    // Latched request fields.
    logic [1:0]  op_reg, op_next;
    logic [31:0] ip_reg, ip_next;
    logic [47:0] smac_reg, smac_next;

    // A sweep cannot tell which result is its final one until it ends, so each
    // result waits in a pending register and moves to the output register when
    // the next one shows up or when the transaction finishes.
    logic    pend_vld_reg, pend_vld_next;
    result_t pend_reg, pend_next;
    logic    out_vld_reg, out_vld_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;

    // Entry memory: one row per slot, single write port, registered read.
    entry_t           mem [ENTRIES];
    entry_t           rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    // Configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            my_ip_reg  <= '0;
            my_mac_reg <= '0;
            sweep_reg  <= 8'd5;
            idle_reg   <= 16'd200;
            rgap_reg   <= 8'd1;
            burst_reg  <= 4'd5;
            bgap_reg   <= 16'd20;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MY_IP:     my_ip_reg  <= cfg_data[31:0];
                CFG_MY_MAC:    my_mac_reg <= cfg_data;
                CFG_SWEEP:     sweep_reg  <= cfg_data[7:0];
                CFG_IDLE:      idle_reg   <= cfg_data[15:0];
                CFG_RETRY_GAP: rgap_reg   <= cfg_data[7:0];
                CFG_BURST:     burst_reg  <= cfg_data[3:0];
                CFG_BACKOFF:   bgap_reg   <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    logic        out_free;
    logic        can_put;
    logic        put_req;
    result_t     put_res;
    logic [7:0]  interval;
    logic [7:0]  cd_inc;
    logic [31:0] since_used;
    logic [31:0] since_sent;
    logic        aged;
    logic        retry_now;
    logic        backoff_now;
    logic        sw_event;
    logic        hdr_ok;
    logic        is_self;
    entry_t      upd;

    assign out_free = !out_vld_reg || m_ready;
    assign can_put  = !pend_vld_reg || out_free;
    assign interval = (sweep_reg == 8'd0) ? 8'd1 : sweep_reg;
    assign cd_inc   = cd_reg + 8'd1;

    assign hdr_ok = (s_hw_addr_len == HW_LEN) && (s_proto_addr_len == PROTO_LEN) &&
                    (s_protocol_type == PROTO_IPV4) && (s_hardware_type == HW_ETHER);
    assign is_self = (ip_reg == LOOPBACK_IP) || (ip_reg == my_ip_reg);

    // Sweep decisions on the row just read.
    assign since_used  = now_reg - rdata_reg.last_used;
    assign since_sent  = now_reg - rdata_reg.last_sent;
    assign aged        = since_used >= {16'd0, idle_reg};
    assign retry_now   = (since_sent >= {24'd0, rgap_reg}) && (rdata_reg.tries < burst_reg);
    assign backoff_now = since_sent >= {16'd0, bgap_reg};
    assign sw_event    = aged || (!rdata_reg.known && (retry_now || backoff_now));

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        cnt_next      = cnt_reg;
        valid_next    = valid_reg;
        now_next      = now_reg;
        cd_next       = cd_reg;
        op_next       = op_reg;
        ip_next       = ip_reg;
        smac_next     = smac_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        out_next      = out_reg;
        out_last_next = out_last_reg;
        put_req       = 1'b0;
        put_res       = '{kind: K_NONE, ip: ip_reg, mac: 48'd0, reason: DR_LENGTH};
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = rdata_reg;
        upd           = rdata_reg;
        s_ready       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next       = s_opcode;
                    ip_next       = s_ip_address;
                    smac_next     = s_sender_mac;
                    idx_next      = '0;
                    free_ok_next  = 1'b0;
                    free_idx_next = '0;
                    cnt_next      = '0;
                    put_res.ip    = s_ip_address;
                    case (s_opcode)
                        OP_RESOLVE: begin
                            if (s_ip_address == my_ip_reg || s_ip_address == LOOPBACK_IP) begin
                                put_req      = 1'b1;
                                put_res.kind = K_RESOLVED;
                                put_res.mac  = my_mac_reg;
                                state_next   = S_FLUSH;
                            end else begin
                                state_next = S_LK_RD;
                            end
                        end
                        OP_FRAME: begin
                            if (s_frame_length != FRAME_LEN) begin
                                put_req        = 1'b1;
                                put_res.kind   = K_DROPPED;
                                put_res.reason = DR_LENGTH;
                                state_next     = S_FLUSH;
                            end else if (!hdr_ok) begin
                                put_req        = 1'b1;
                                put_res.kind   = K_DROPPED;
                                put_res.reason = DR_FIELDS;
                                state_next     = S_FLUSH;
                            end else if (s_arp_operation == ARP_REQUEST) begin
                                put_req    = 1'b1;
                                state_next = S_FLUSH;
                                if (s_target_ip == my_ip_reg) begin
                                    put_res.kind = K_REPLY;
                                    put_res.mac  = s_sender_mac;
                                end else begin
                                    put_res.kind   = K_DROPPED;
                                    put_res.reason = DR_NOTME;
                                end
                            end else if (s_arp_operation != ARP_REPLY) begin
                                put_req        = 1'b1;
                                put_res.kind   = K_DROPPED;
                                put_res.reason = DR_OPER;
                                state_next     = S_FLUSH;
                            end else begin
                                state_next = S_LK_RD;
                            end
                        end
                        OP_TICK: begin
                            now_next = now_reg + 32'd1;
                            if (cd_inc >= interval) begin
                                cd_next    = '0;
                                state_next = S_SW_RD;
                            end else begin
                                cd_next = cd_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Lookup: the memory presents row idx in the next cycle. Free
            // slots are noted on the way so a miss needs no second pass.
            S_LK_RD: begin
                if (valid_reg[idx_reg]) begin
                    state_next = S_LK_EV;
                end else begin
                    if (!free_ok_reg) begin
                        free_ok_next  = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_MISS;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_LK_EV: begin
                if (rdata_reg.ip == ip_reg) begin
                    put_req    = 1'b1;
                    state_next = S_FLUSH;
                    if (op_reg == OP_RESOLVE) begin
                        if (rdata_reg.known) begin
                            upd.last_used = now_reg;
                            mem_we        = 1'b1;
                            mem_wdata     = upd;
                            put_res.kind  = K_RESOLVED;
                            put_res.mac   = rdata_reg.mac;
                        end else begin
                            put_res.kind = K_HELD;
                        end
                    end else begin
                        // A reply resolves a pending entry or refreshes a known one.
                        upd.mac       = smac_reg;
                        upd.known     = 1'b1;
                        upd.last_used = now_reg;
                        mem_we        = 1'b1;
                        mem_wdata     = upd;
                        put_res.kind  = rdata_reg.known ? K_LEARNED : K_RELEASE;
                    end
                end else if (idx_reg == LAST_IDX) begin
                    state_next = S_MISS;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_LK_RD;
                end
            end

            S_MISS: begin
                put_req    = 1'b1;
                state_next = S_FLUSH;
                mem_waddr  = free_idx_reg;
                mem_wdata  = '{ip: ip_reg, mac: 48'd0, known: 1'b0, last_used: now_reg,
                               last_sent: now_reg, tries: 4'd1};
                if (op_reg == OP_FRAME && is_self) begin
                    put_res.kind = K_NONE;
                end else if (!free_ok_reg) begin
                    put_res.kind = K_FULL;
                end else begin
                    mem_we                  = 1'b1;
                    valid_next[free_idx_reg] = 1'b1;
                    if (op_reg == OP_RESOLVE) begin
                        put_res.kind = K_REQUEST;
                    end else begin
                        mem_wdata.mac   = smac_reg;
                        mem_wdata.known = 1'b1;
                        put_res.kind    = K_LEARNED;
                    end
                end
            end

            // Sweep in slot order: aging first, then request resends.
            S_SW_RD: begin
                if (valid_reg[idx_reg]) begin
                    state_next = S_SW_EV;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = pend_vld_reg ? S_FLUSH : S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_SW_EV: begin
                if (!sw_event || can_put) begin
                    if (sw_event) begin
                        put_req    = 1'b1;
                        put_res.ip = rdata_reg.ip;
                        cnt_next   = cnt_reg + 5'd1;
                        if (aged) begin
                            valid_next[idx_reg] = 1'b0;
                            put_res.kind        = K_AGED;
                        end else begin
                            upd.last_sent = now_reg;
                            upd.tries     = retry_now ? rdata_reg.tries + 4'd1 : 4'd1;
                            mem_we        = 1'b1;
                            mem_wdata     = upd;
                            put_res.kind  = K_REQUEST;
                        end
                    end
                    if (idx_reg == LAST_IDX || (sw_event && cnt_reg + 5'd1 == MAX_RES_CNT)) begin
                        state_next = (pend_vld_reg || sw_event) ? S_FLUSH : S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SW_RD;
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_next      = pend_reg;
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A new result pushes the previous pending one out as a non-final result.
        if (put_req) begin
            if (pend_vld_reg) begin
                out_vld_next  = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_next     = put_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            now_reg      <= '0;
            cd_reg       <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            free_ok_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            now_reg      <= now_next;
            cd_reg       <= cd_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            free_ok_reg  <= free_ok_next;
        end
        free_idx_reg <= free_idx_next;
        op_reg       <= op_next;
        ip_reg       <= ip_next;
        smac_reg     <= smac_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = out_vld_reg;
    assign m_result_kind = out_reg.kind;
    assign m_peer_ip     = out_reg.ip;
    assign m_peer_mac    = out_reg.mac;
    assign m_drop_reason = out_reg.reason;
    assign m_last        = out_last_reg;

    // Nothing may be left pending once the controller is back to idle.
    `ASSERT_IMPLY(a_idle_no_pend, state_reg == S_IDLE, !pend_vld_reg, "pending result in idle")
    // A resolve request always yields a result, so it never returns straight to idle.
    `ASSERT_NEXT(a_resolve_busy, s_valid && s_ready && s_opcode == OP_RESOLVE,
                 state_reg != S_IDLE, "resolve finished without result")
    // A sweep never reports more results than the limit.
    `ASSERT_ALWAYS(a_cnt_limit, cnt_reg <= MAX_RES_CNT, "sweep result count over limit")
    // Every accepted tick advances time by one second.
    `ASSERT_NEXT(a_tick_time, s_valid && s_ready && s_opcode == OP_TICK,
                 now_reg == $past(now_reg) + 32'd1, "tick did not advance time")

endmodule

`default_nettype wire
